/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros included by key_state_consistency_filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kscf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscf_pkg
// Types and codes of the key state consistency filter.
// ----------------------------------------------------------------------------
package kscf_pkg;

    // Event type of a key event.
    localparam logic [4:0] EV_KEY = 5'd1;

    // Values carried by a key event.
    localparam logic [31:0] VAL_RELEASE = 32'd0;
    localparam logic [31:0] VAL_PRESS   = 32'd1;
    localparam logic [31:0] VAL_REPEAT  = 32'd2;

    // Reason codes of a result item.
    localparam logic [1:0] RSN_OK             = 2'd0;
    localparam logic [1:0] RSN_DOUBLE_PRESS   = 2'd1;
    localparam logic [1:0] RSN_ORPHAN_REPEAT  = 2'd2;
    localparam logic [1:0] RSN_ORPHAN_RELEASE = 2'd3;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 8;

    // Decoded event value.
    typedef enum logic [1:0] {
        VK_RELEASE = 2'd0,
        VK_PRESS   = 2'd1,
        VK_REPEAT  = 2'd2,
        VK_OTHER   = 2'd3
    } val_kind_t;

    // Control states, one-hot.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

endpackage

/* rtl/key_state_consistency_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_state_consistency_filter
// Tracks one pressed bit per key code and flags inconsistent key events.
// ----------------------------------------------------------------------------
// Usage:
// Input events arrive on the s_ stream, one item per handshake, carrying the
// event type, code and value. Each item yields exactly one result item on the
// m_ stream with a drop flag and a reason code. Key events (type 1) whose code
// is below NUM_KEYS are checked against a pressed bit held in an on-chip
// memory of NUM_KEYS one-bit entries; all other events pass with reason ok.
// An item is handled in order: the accept edge issues the memory read, and
// a later edge, once the output register is free, modifies and writes the bit
// back and loads the result register. The memory read is registered, so a new
// item is accepted only after the lookup of the last one has finished. Because
// the write-back lands before the next read is issued, no forwarding is needed.
// After reset the block sweeps the memory to zero, one entry per cycle, and
// s_tready stays low during that sweep.
// The result sits in an output register. A new item can be accepted while a
// result waits; if the receiver stalls, the lookup holds its read data and
// waits until the output register frees up before writing back.
// ----------------------------------------------------------------------------
module key_state_consistency_filter #(
    parameter int unsigned NUM_KEYS = 768
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: ev_kind [4:0], ev_code [20:5], ev_value [52:21], zero [55:53]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [kscf_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata: drop [0], reason [2:1], zero [7:3]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [kscf_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import kscf_pkg::*;

`include "assert_macros.svh"

    localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [16:0] KEY_LIMIT = 17'(NUM_KEYS);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_KEYS - 1);

    // Input fields.
    logic [4:0]  ev_kind;
    logic [15:0] ev_code;
    logic [31:0] ev_value;

    assign ev_kind  = s_tdata[4:0];
    assign ev_code  = s_tdata[20:5];
    assign ev_value = s_tdata[52:21];

    // Control and payload registers.
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic            hit_reg;
    val_kind_t       val_kind_reg;
    logic [AW-1:0]   addr_reg;
    logic            rd_data_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_drop_reg;
    logic [1:0]      out_reason_reg;

    // Key state memory.
    logic            key_down_mem [NUM_KEYS];

    logic            accept;
    logic            in_hit;
    val_kind_t       in_val_kind;
    logic            out_free;
    logic            finish;
    logic [1:0]      reason;
    logic            key_wr_en;
    logic            key_wr_bit;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    logic            mem_wr_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign finish   = (state_reg == ST_LOOKUP) && out_free;

    // Only key events with an in-range code touch the memory.
    assign in_hit = (ev_kind == EV_KEY) && ({1'b0, ev_code} < KEY_LIMIT);

    always_comb
    begin
        if (ev_value == VAL_PRESS)
        begin
            in_val_kind = VK_PRESS;
        end
        else if (ev_value == VAL_REPEAT)
        begin
            in_val_kind = VK_REPEAT;
        end
        else if (ev_value == VAL_RELEASE)
        begin
            in_val_kind = VK_RELEASE;
        end
        else
        begin
            in_val_kind = VK_OTHER;
        end
    end

    // Check the stored bit and work out the new one.
    always_comb
    begin
        reason     = RSN_OK;
        key_wr_en  = 1'b0;
        key_wr_bit = 1'b0;
        if (hit_reg)
        begin
            case (val_kind_reg)
                VK_PRESS:
                begin
                    if (rd_data_reg)
                    begin
                        reason = RSN_DOUBLE_PRESS;
                    end
                    key_wr_en  = 1'b1;
                    key_wr_bit = 1'b1;
                end
                VK_REPEAT:
                begin
                    if (!rd_data_reg)
                    begin
                        reason = RSN_ORPHAN_REPEAT;
                    end
                end
                VK_RELEASE:
                begin
                    if (!rd_data_reg)
                    begin
                        reason = RSN_ORPHAN_RELEASE;
                    end
                    key_wr_en  = 1'b1;
                    key_wr_bit = 1'b0;
                end
                default:
                begin
                    reason = RSN_OK;
                end
            endcase
        end
    end

    // Single write port shared by the clearing sweep and the write-back.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_reg;
            mem_wr_data = 1'b0;
        end
        else
        begin
            mem_wr_en   = finish && key_wr_en;
            mem_wr_addr = addr_reg;
            mem_wr_data = key_wr_bit;
        end
    end

    // Next state.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload captured at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= in_hit;
            val_kind_reg <= in_val_kind;
            addr_reg     <= ev_code[AW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_drop_reg   <= (reason != RSN_OK);
            out_reason_reg <= reason;
        end
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            key_down_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Memory read port, registered; read only for in-range key events.
    always_ff @(posedge clk)
    begin
        if (accept && in_hit)
        begin
            rd_data_reg <= key_down_mem[ev_code[AW-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reason_reg, out_drop_reg};

    // An accepted item always moves into the lookup.
    `ASSERT_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP,
        "accepted item did not enter lookup")
    // The drop flag agrees with the reason code.
    `ASSERT_IMP(a_drop_matches_reason, m_tvalid,
        m_tdata[0] == (m_tdata[2:1] != RSN_OK),
        "drop flag disagrees with reason")
    // A new result only comes out of a finished lookup.
    `ASSERT_IMP(a_result_from_lookup, $rose(m_tvalid),
        $past(state_reg == ST_LOOKUP),
        "result appeared without a lookup")
    // The memory is written only by the sweep or a finishing lookup.
    `ASSERT_IMP(a_write_source, mem_wr_en,
        (state_reg == ST_CLEAR) || finish,
        "memory written outside sweep or write-back")

endmodule
